>>> hw/rtl/rau_pkg.sv
// Package of the rational arithmetic unit: operation codes, widths and the
// item and result types shared by the front, queue and back modules.
// No dependencies.
package rau_pkg;

  localparam int OP_W   = 32;
  localparam int RES_W  = 64;
  localparam int QDEPTH = 2;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  // Classified item: saturated, sign-normalized operands and error flag.
  typedef struct packed {
    logic [1:0]              mode;
    logic signed [OP_W-1:0]  an;
    logic signed [OP_W-1:0]  ad;
    logic signed [OP_W-1:0]  bn;
    logic signed [OP_W-1:0]  bd;
    logic                    err;
  } item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] num;
    logic signed [RES_W-1:0] den;
    logic                    err;
  } res_t;

endpackage

>>> hw/rtl/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: front, queue and back.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
//  channel   ports                                   handshake
//  input     in_mode, in_a_num/den, in_b_num/den     push / full
//  result    out_res_num, out_res_den, out_error     empty / pop
//
// In the back unit an item is taken from the queue, then goes through four
// multiplier steps, a binary gcd at one step a cycle plus a finishing step,
// two 64-bit restoring divisions and the load of the result register.
// Error items go straight to the result register (zero denominator) or
// do so after the multiplier steps (divide by zero value).
// Reset is synchronous, active low; it empties the queue and result register.
// The two-entry queue lets the input keep taking items while the back works
// or while a result waits to be popped.
module rational_arithmetic_unit_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [31:0] in_b_den,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_res_num,
  output logic [63:0] out_res_den,
  output logic        out_error
);
  import rau_pkg::*;

  item_t item, q_item;
  res_t  res;
  logic  q_valid, q_pop, out_valid;

  // classify the incoming transfer
  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .mode_i  (in_mode),
    .a_num_i (in_a_num),
    .a_den_i (in_a_den),
    .b_num_i (in_b_num),
    .b_den_i (in_b_den),
    .item_o  (item)
  );

  // hold classified items until the back is free
  rau_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .data_i  (item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  rau_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_data_i    (q_item),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_o       (res)
  );

  assign empty       = !out_valid;
  assign out_res_num = res.num;
  assign out_res_den = res.den;
  assign out_error   = res.err;

endmodule

>>> hw/rtl/rau_front.sv
// Front end: saturates operand parts, normalizes signs and flags zero
// denominators. Depends on rau_pkg.
module rau_front #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic [1:0]                  mode_i,
  input  logic [rau_pkg::OP_W-1:0]    a_num_i,
  input  logic [rau_pkg::OP_W-1:0]    a_den_i,
  input  logic [rau_pkg::OP_W-1:0]    b_num_i,
  input  logic [rau_pkg::OP_W-1:0]    b_den_i,
  output rau_pkg::item_t              item_o
);
  import rau_pkg::*;

  localparam logic [OPERAND_WIDTH-1:0] MIN_V = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};

  function automatic logic signed [OP_W-1:0] sat_part(input logic [OP_W-1:0] v);
    logic signed [OPERAND_WIDTH-1:0] p;
    logic signed [OP_W-1:0]          x;
    p = v[OPERAND_WIDTH-1:0];
    x = OP_W'(p);
    if (p == MIN_V) x = x + OP_W'(1);
    return x;
  endfunction

  logic signed [OP_W-1:0] an, ad, bn, bd;

  always_comb begin
    an = sat_part(a_num_i);
    ad = sat_part(a_den_i);
    bn = sat_part(b_num_i);
    bd = sat_part(b_den_i);
    item_o.mode = mode_i;
    item_o.err  = (ad == '0) || (bd == '0);
    // flip both parts only when both are negative
    if (an[OP_W-1] && ad[OP_W-1]) begin
      item_o.an = -an;
      item_o.ad = -ad;
    end else begin
      item_o.an = an;
      item_o.ad = ad;
    end
    if (bn[OP_W-1] && bd[OP_W-1]) begin
      item_o.bn = -bn;
      item_o.bd = -bd;
    end else begin
      item_o.bn = bn;
      item_o.bd = bd;
    end
  end

endmodule

>>> hw/rtl/rau_queue.sv
// Two-entry queue between front and back.
// Depends on rau_pkg.
module rau_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  rau_pkg::item_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output rau_pkg::item_t  data_o
);
  import rau_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  item_t          mem_r [QDEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [PW:0]    cnt_r;
  logic           do_push, do_pop;

  assign full_o  = (cnt_r == (PW+1)'(QDEPTH));
  assign valid_o = (cnt_r != '0);
  assign data_o  = mem_r[rd_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= data_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PW'(QDEPTH-1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PW'(QDEPTH-1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> hw/rtl/rau_back.sv
// Back end: cross-multiplies, finds the binary gcd, divides both parts by
// it and holds the result in the output register. Depends on rau_pkg.
module rau_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid_i,
  input  rau_pkg::item_t  q_data_i,
  output logic            q_pop_o,
  input  logic            pop_i,
  output logic            out_valid_o,
  output rau_pkg::res_t   out_o
);
  import rau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_GCD, S_DIVN, S_DIVD, S_DONE
  } state_t;

  state_t                  state_r;
  item_t                   it_r;
  logic [1:0]              step_r;
  logic signed [RES_W-1:0] prod_r, rn_r;
  logic [RES_W-1:0]        u_r, v_r, g_r, magn_r, magd_r, qn_r;
  logic                    negn_r, negd_r;
  logic [6:0]              k_r;
  logic [RES_W:0]          rem_r;
  logic [RES_W-1:0]        dvd_r;
  logic [5:0]              cnt_r;
  res_t                    hold_r, out_r;
  logic                    out_valid_r;

  logic signed [OP_W-1:0]  mx, my;
  logic signed [RES_W-1:0] mprod;
  logic [RES_W:0]          rem_sh, diff;
  logic                    ge;
  logic [RES_W-1:0]        q_last;
  logic                    add_sub;
  logic                    load_out;

  assign q_pop_o     = (state_r == S_IDLE);
  assign out_valid_o = out_valid_r;
  assign out_o       = out_r;
  assign add_sub     = (it_r.mode == MODE_ADD) || (it_r.mode == MODE_SUB);
  assign load_out    = (state_r == S_DONE) && (!out_valid_r || pop_i);

  // operand select for one product per step
  always_comb begin
    case (step_r)
      2'd0: begin
        mx = it_r.an;
        my = (it_r.mode == MODE_MUL) ? it_r.bn : it_r.bd;
      end
      2'd1: begin
        mx = add_sub ? it_r.bn : '0;
        my = it_r.ad;
      end
      default: begin
        mx = it_r.ad;
        my = (it_r.mode == MODE_DIV) ? it_r.bn : it_r.bd;
      end
    endcase
    mprod  = RES_W'(mx) * RES_W'(my);
    rem_sh = {rem_r[RES_W-1:0], dvd_r[RES_W-1]};
    diff   = rem_sh - {1'b0, g_r};
    ge     = !diff[RES_W];
    q_last = {dvd_r[RES_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (pop_i && out_valid_r) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid_i) begin
            it_r   <= q_data_i;
            step_r <= '0;
            if (q_data_i.err) begin
              hold_r  <= '{num: '0, den: '0, err: 1'b1};
              state_r <= S_DONE;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r <= mprod;
          step_r <= step_r + 1'b1;
          case (step_r)
            2'd1: rn_r <= prod_r;
            2'd2: rn_r <= (it_r.mode == MODE_SUB) ? rn_r - prod_r : rn_r + prod_r;
            2'd3: begin
              if (prod_r == '0) begin
                hold_r  <= '{num: '0, den: '0, err: 1'b1};
                state_r <= S_DONE;
              end else begin
                u_r     <= rn_r[RES_W-1] ? -rn_r : rn_r;
                magn_r  <= rn_r[RES_W-1] ? -rn_r : rn_r;
                v_r     <= prod_r[RES_W-1] ? -prod_r : prod_r;
                magd_r  <= prod_r[RES_W-1] ? -prod_r : prod_r;
                negn_r  <= rn_r[RES_W-1];
                negd_r  <= prod_r[RES_W-1];
                k_r     <= '0;
                state_r <= S_GCD;
              end
            end
            default: ;
          endcase
        end
        S_GCD: begin
          // one binary gcd step a cycle
          if (u_r == '0) begin
            g_r     <= v_r << k_r;
            rem_r   <= '0;
            dvd_r   <= magn_r;
            cnt_r   <= '0;
            state_r <= S_DIVN;
          end else if (!u_r[0] && !v_r[0]) begin
            u_r <= u_r >> 1;
            v_r <= v_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!u_r[0]) begin
            u_r <= u_r >> 1;
          end else if (!v_r[0]) begin
            v_r <= v_r >> 1;
          end else if (u_r >= v_r) begin
            u_r <= (u_r - v_r) >> 1;
          end else begin
            v_r <= (v_r - u_r) >> 1;
          end
        end
        S_DIVN, S_DIVD: begin
          // restoring division, one quotient bit a cycle
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            rem_r <= '0;
            if (state_r == S_DIVN) begin
              qn_r    <= q_last;
              dvd_r   <= magd_r;
              state_r <= S_DIVD;
            end else begin
              hold_r.num <= (negn_r && !negd_r) ? -qn_r : qn_r;
              hold_r.den <= (negd_r && !negn_r) ? -q_last : q_last;
              hold_r.err <= 1'b0;
              state_r    <= S_DONE;
            end
          end else begin
            rem_r <= ge ? diff : rem_sh;
            dvd_r <= q_last;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_r   <= hold_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVN || state_r == S_DIVD) |-> (g_r != '0))
    else $error("division by zero gcd");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.err) |-> (out_r.num == '0 && out_r.den == '0))
    else $error("error result with nonzero parts");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_valid_i) |=> (state_r == S_MUL || state_r == S_DONE))
    else $error("item taken but not started");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for rational_arithmetic_unit_core: fraction add, sub, mul, div.
// Depends on rau_pkg and the core; a scoreboard class predicts each reduced result.
`timescale 1ns / 100ps

module testbench;
  import rau_pkg::*;

  localparam int N_RANDOM     = 1700;
  localparam int QUIET_TAIL   = 150;
  localparam int HOLD_CYCLES  = 1500;
  localparam int HOLD_AT      = 300;
  localparam int WATCHDOG_MAX = 20000;
  localparam int DRAIN_CYCLES = 400;

  // Golden fraction arithmetic plus the queue of expected reduced results.
  class rau_scoreboard;
    res_t pending[$];
    int   errors;

    static function longint sat_part(logic [31:0] v);
      longint x;
      x = longint'($signed(v));
      if (v == 32'h8000_0000) x = x + 1;
      return x;
    endfunction

    static function longint unsigned mag(longint x);
      return (x < 0) ? longint'(0) - x : x;
    endfunction

    static function void reduce_frac(ref longint n, ref longint d);
      longint unsigned p, q, t, g;
      p = mag(n);
      q = mag(d);
      while (q != 0) begin
        t = p % q;
        p = q;
        q = t;
      end
      g = (p == 0) ? 1 : p;
      n = (n < 0) ? -longint'(mag(n) / g) : longint'(mag(n) / g);
      d = (d < 0) ? -longint'(mag(d) / g) : longint'(mag(d) / g);
      if (n < 0 && d < 0) begin
        n = -n;
        d = -d;
      end
    endfunction

    static function res_t combine(logic [1:0] m, logic [31:0] an_i, logic [31:0] ad_i,
                                  logic [31:0] bn_i, logic [31:0] bd_i);
      longint an, ad, bn, bd, rn, rd;
      res_t r;
      an = sat_part(an_i);
      ad = sat_part(ad_i);
      bn = sat_part(bn_i);
      bd = sat_part(bd_i);
      r = '{num: '0, den: '0, err: 1'b1};
      if (ad == 0 || bd == 0) return r;
      reduce_frac(an, ad);
      reduce_frac(bn, bd);
      case (m)
        MODE_ADD: begin rn = an * bd + bn * ad; rd = ad * bd; end
        MODE_SUB: begin rn = an * bd - bn * ad; rd = ad * bd; end
        MODE_MUL: begin rn = an * bn;           rd = ad * bd; end
        default:  begin rn = an * bd;           rd = ad * bn; end
      endcase
      if (rd == 0) return r;
      reduce_frac(rn, rd);
      r.num = rn;
      r.den = rd;
      r.err = 1'b0;
      return r;
    endfunction

    function void note_item(logic [1:0] m, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
      pending.push_back(combine(m, an, ad, bn, bd));
    endfunction

    function void check_result(logic [63:0] n, logic [63:0] d, logic e);
      res_t x;
      if (pending.size() == 0) begin
        $display("%0t unexpected result num %0d den %0d err %0b",
                 $time, $signed(n), $signed(d), e);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (n !== x.num) begin
        $display("%0t res_num exp %0d got %0d", $time, x.num, $signed(n));
        errors++;
      end
      if (d !== x.den) begin
        $display("%0t res_den exp %0d got %0d", $time, x.den, $signed(d));
        errors++;
      end
      if (e !== x.err) begin
        $display("%0t error exp %0b got %0b", $time, x.err, e);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_a_num = '0, in_a_den = 32'd1, in_b_num = '0, in_b_den = 32'd1;
  logic        full, empty, out_error;
  logic [63:0] out_res_num, out_res_den;

  rau_scoreboard sb = new();
  int  n_in_accepted = 0;
  int  idle_count = 0;
  bit  quiet = 1'b0;      // no idling in the tail of the run
  int  rx_gap = 0;
  int  rx_hold = 0;
  bit  hold_done = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rational_arithmetic_unit_core u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_mode(in_mode), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .empty(empty), .pop(pop),
    .out_res_num(out_res_num), .out_res_den(out_res_den), .out_error(out_error)
  );

  // Receiver: check each result transfer, drop pop in random bursts, and hold off
  // once for a long stretch so the queue fills up and full stalls the sender.
  // The watchdog lives here too: it counts cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) sb.check_result(out_res_num, out_res_den, out_error);
      if ((pop && !empty) || (push && !full)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_MAX) begin
        $display("[rational_arithmetic_unit_core] ERROR");
        $finish;
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        pop <= 1'b0;
      end else if (!hold_done && n_in_accepted >= HOLD_AT) begin
        hold_done <= 1'b1;
        rx_hold <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        rx_gap <= $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Operand part generator: extremes, small values, zeros and fully random words.
  function automatic logic [31:0] pick_part(bit is_den);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = 32'h8000_0001;
      3:       v = is_den ? (($urandom_range(0, 5) == 0) ? 32'd0 : 32'hffff_ffff) : 32'd0;
      4, 5, 6: begin
        v = $urandom_range(1, 24);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Drive one item and hold it until the transfer; optional gap afterward.
  task automatic send_item(logic [1:0] m, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    push     <= 1'b1;
    in_mode  <= m;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(m, an, ad, bn, bd);
    n_in_accepted++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [1:0] m;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation at the extremes and the named corner cases.
    for (int k = 0; k < 4; k++) begin
      m = k[1:0];
      send_item(m, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 32'h7fff_ffff);
      send_item(m, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_fffe);
      send_item(m, 32'd3, 32'hffff_fffa, 32'hffff_fffe, 32'd4);
    end
    send_item(MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd2);           // zero first denominator
    send_item(MODE_MUL, 32'd1, 32'd2, 32'd5, 32'd0);           // zero second denominator
    send_item(MODE_DIV, 32'd1, 32'd2, 32'd0, 32'd7);           // divide by zero-valued b
    send_item(MODE_DIV, 32'd0, 32'd3, 32'd0, 32'hffff_ffff);   // 0 over 0-valued b
    send_item(MODE_SUB, 32'd2, 32'd4, 32'd1, 32'd2);           // zero result, 0/1
    send_item(MODE_SUB, 32'd2, 32'hffff_fffc, 32'd1, 32'hffff_fffe); // zero with negative den
    send_item(MODE_MUL, 32'hffff_ffff, 32'd2, 32'd1, 32'hffff_fffd); // negative den kept
    send_item(MODE_ADD, 32'hffff_fffe, 32'hffff_fffc, 32'hffff_ffff, 32'hffff_fffd);
    send_item(MODE_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000);

    // Random part; drop idling for the tail of the run.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i >= N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      m = 2'($urandom_range(0, 3));
      send_item(m, pick_part(0), pick_part(1), pick_part(0), pick_part(1));
    end
    push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("[rational_arithmetic_unit_core] OK");
    end else begin
      $display("[rational_arithmetic_unit_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_front.sv
hw/rtl/rau_queue.sv
hw/rtl/rau_back.sv
hw/rtl/rational_arithmetic_unit_core.sv
sim/testbench.sv
